@@ design/dwq_pkg.sv @@
// ----------------------------------------------------------------------------
// dwq_pkg
// Shared sizes, codes and controller/datapath signal bundles for the device
// wait queues.
// ----------------------------------------------------------------------------
package dwq_pkg;

  localparam int NUM_DEVICES = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int TOTAL       = NUM_DEVICES * QUEUE_DEPTH;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int DEV_W  = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  localparam int ID_W   = 16;
  localparam int TIME_W = 16;
  localparam int DATA_W = ID_W + TIME_W;

  typedef enum logic [1:0] {
    REQ_ENQ,
    REQ_DEQ,
    REQ_TICK,
    REQ_TAKE
  } req_kind_t;

  typedef enum logic [1:0] {
    STS_OK,
    STS_FULL,
    STS_NONE
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DEQ_CAP,
    ST_TICK_RD,
    ST_TICK_WR,
    ST_FIND,
    ST_TAKE_CAP,
    ST_TAKE_WR,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic latch_req;
    logic fail_full;
    logic fail_none;
    logic enq;
    logic deq_rd;
    logic deq_cap;
    logic tick_rd;
    logic tick_wr;
    logic find_step;
    logic take_rd;
    logic take_cap;
    logic take_wr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    req_kind_t kind;
    logic      dev_ok;
    logic      queue_full;
    logic      queue_empty;
    logic      scan_done;
    logic      scan_hit;
    logic      tick_last;
    logic      out_free;
  } sts_t;

  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return PTR_W'(sum);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_of(input logic [DEV_W-1:0] dev,
                                                input logic [PTR_W-1:0] pos);
    return ADDR_W'(dev) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos);
  endfunction

endpackage

@@ design/dwq_if.sv @@
// ----------------------------------------------------------------------------
// dwq request and response channels
// Valid/ready channels carrying one request or one response.
// ----------------------------------------------------------------------------
interface dwq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [1:0]  device;
  logic [15:0] process_id;
  logic [15:0] io_time;

  modport source (output valid, req_type, device, process_id, io_time, input ready);
  modport sink (input valid, req_type, device, process_id, io_time, output ready);
endinterface

interface dwq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] out_process_id;
  logic [15:0] out_time_left;
  logic [3:0]  finished_mask;
  logic [4:0]  fill_count;

  modport source (output valid, status, out_process_id, out_time_left, finished_mask,
                  fill_count, input ready);
  modport sink (input valid, status, out_process_id, out_time_left, finished_mask,
                fill_count, output ready);
endinterface

@@ design/dwq_ram.sv @@
// ----------------------------------------------------------------------------
// dwq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dwq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/dwq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dwq_ctrl
// Request sequencer: decodes each request and steps the datapath through it.
// ----------------------------------------------------------------------------
module dwq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  dwq_pkg::sts_t sts,
  output dwq_pkg::cmd_t cmd
);

  dwq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dwq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      dwq_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch_req = 1'b1;
          state_next    = dwq_pkg::ST_DECODE;
        end
      end
      dwq_pkg::ST_DECODE: begin
        unique case (sts.kind)
          dwq_pkg::REQ_ENQ: begin
            if (!sts.dev_ok || sts.queue_full) begin
              cmd.fail_full = 1'b1;
            end else begin
              cmd.enq = 1'b1;
            end
            state_next = dwq_pkg::ST_RESP;
          end
          dwq_pkg::REQ_DEQ: begin
            if (!sts.dev_ok || sts.queue_empty) begin
              cmd.fail_none = 1'b1;
              state_next    = dwq_pkg::ST_RESP;
            end else begin
              cmd.deq_rd = 1'b1;
              state_next = dwq_pkg::ST_DEQ_CAP;
            end
          end
          dwq_pkg::REQ_TICK: begin
            state_next = dwq_pkg::ST_TICK_RD;
          end
          dwq_pkg::REQ_TAKE: begin
            if (!sts.dev_ok) begin
              cmd.fail_none = 1'b1;
              state_next    = dwq_pkg::ST_RESP;
            end else begin
              state_next = dwq_pkg::ST_FIND;
            end
          end
        endcase
      end
      dwq_pkg::ST_DEQ_CAP: begin
        cmd.deq_cap = 1'b1;
        state_next  = dwq_pkg::ST_RESP;
      end
      dwq_pkg::ST_TICK_RD: begin
        cmd.tick_rd = 1'b1;
        state_next  = dwq_pkg::ST_TICK_WR;
      end
      dwq_pkg::ST_TICK_WR: begin
        cmd.tick_wr = 1'b1;
        state_next  = sts.tick_last ? dwq_pkg::ST_RESP : dwq_pkg::ST_TICK_RD;
      end
      dwq_pkg::ST_FIND: begin
        priority if (sts.scan_done) begin
          cmd.fail_none = 1'b1;
          state_next    = dwq_pkg::ST_RESP;
        end else if (sts.scan_hit) begin
          cmd.take_rd = 1'b1;
          state_next  = dwq_pkg::ST_TAKE_CAP;
        end else begin
          cmd.find_step = 1'b1;
        end
      end
      dwq_pkg::ST_TAKE_CAP: begin
        cmd.take_cap = 1'b1;
        state_next   = dwq_pkg::ST_TAKE_WR;
      end
      dwq_pkg::ST_TAKE_WR: begin
        cmd.take_wr = 1'b1;
        state_next  = dwq_pkg::ST_RESP;
      end
      dwq_pkg::ST_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = dwq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dwq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/dwq_datapath.sv @@
// ----------------------------------------------------------------------------
// dwq_datapath
// Queue pointers, entry store, per-slot occupancy and zero flags, and the
// response register.
// ----------------------------------------------------------------------------
module dwq_datapath (
  input  logic          clk,
  input  logic          rst,
  input  dwq_pkg::cmd_t cmd,
  output dwq_pkg::sts_t sts,
  input  logic [1:0]    req_type,
  input  logic [1:0]    device,
  input  logic [15:0]   process_id,
  input  logic [15:0]   io_time,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    status,
  output logic [15:0]   out_process_id,
  output logic [15:0]   out_time_left,
  output logic [3:0]    finished_mask,
  output logic [4:0]    fill_count
);

  logic [dwq_pkg::PTR_W-1:0]  head [dwq_pkg::NUM_DEVICES];
  logic [dwq_pkg::PTR_W-1:0]  tail [dwq_pkg::NUM_DEVICES];
  logic [dwq_pkg::CNT_W-1:0]  count [dwq_pkg::NUM_DEVICES];
  logic [dwq_pkg::TOTAL-1:0]  occ;
  logic [dwq_pkg::TOTAL-1:0]  zf;

  dwq_pkg::req_kind_t         kind;
  logic [1:0]                 dev_q;
  logic [15:0]                pid_q;
  logic [15:0]                tim_q;
  logic [dwq_pkg::CNT_W-1:0]  scan_pos;
  logic [dwq_pkg::ADDR_W-1:0] tick_addr;
  logic [dwq_pkg::ADDR_W-1:0] take_slot;
  dwq_pkg::status_t           res_status;
  logic [15:0]                res_pid;
  logic [15:0]                res_time;

  logic [dwq_pkg::DEV_W-1:0]  dev_idx;
  logic                       dev_ok;
  logic [dwq_pkg::PTR_W-1:0]  tail_prev;
  logic [dwq_pkg::ADDR_W-1:0] scan_slot;
  logic [dwq_pkg::ADDR_W-1:0] head_slot;
  logic [dwq_pkg::ADDR_W-1:0] tail_slot;
  logic [dwq_pkg::ADDR_W-1:0] last_slot;
  logic [15:0]                tm_dec;
  logic [dwq_pkg::TOTAL-1:0]  oz;
  logic [3:0]                 mask;

  logic                       ram_wr_en;
  logic [dwq_pkg::ADDR_W-1:0] ram_wr_addr;
  logic [dwq_pkg::DATA_W-1:0] ram_wr_data;
  logic                       ram_rd_en;
  logic [dwq_pkg::ADDR_W-1:0] ram_rd_addr;
  logic [dwq_pkg::DATA_W-1:0] ram_rd_data;

  assign dev_idx   = dwq_pkg::DEV_W'(dev_q);
  assign dev_ok    = int'(dev_q) < dwq_pkg::NUM_DEVICES;
  assign tail_prev = (tail[dev_idx] == '0) ? dwq_pkg::PTR_W'(dwq_pkg::QUEUE_DEPTH - 1)
                                           : tail[dev_idx] - dwq_pkg::PTR_W'(1);
  assign scan_slot = dwq_pkg::slot_of(dev_idx, dwq_pkg::ring_add(head[dev_idx], scan_pos));
  assign head_slot = dwq_pkg::slot_of(dev_idx, head[dev_idx]);
  assign tail_slot = dwq_pkg::slot_of(dev_idx, tail[dev_idx]);
  assign last_slot = dwq_pkg::slot_of(dev_idx, tail_prev);
  assign tm_dec    = (ram_rd_data[15:0] == '0) ? 16'd0 : ram_rd_data[15:0] - 16'd1;
  assign oz        = occ & zf;

  for (genvar d = 0; d < 4; d++) begin : g_mask
    if (d < dwq_pkg::NUM_DEVICES) begin : g_on
      assign mask[d] = |oz[d*dwq_pkg::QUEUE_DEPTH +: dwq_pkg::QUEUE_DEPTH];
    end else begin : g_off
      assign mask[d] = 1'b0;
    end
  end

  always_comb begin
    sts.kind        = kind;
    sts.dev_ok      = dev_ok;
    sts.queue_full  = count[dev_idx] >= dwq_pkg::CNT_W'(dwq_pkg::QUEUE_DEPTH);
    sts.queue_empty = count[dev_idx] == '0;
    sts.scan_done   = scan_pos == count[dev_idx];
    sts.scan_hit    = zf[scan_slot];
    sts.tick_last   = tick_addr == dwq_pkg::ADDR_W'(dwq_pkg::TOTAL - 1);
    sts.out_free    = !out_valid || out_ready;
  end

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = tail_slot;
    ram_wr_data = {pid_q, tim_q};
    ram_rd_en   = 1'b0;
    ram_rd_addr = head_slot;
    priority if (cmd.enq) begin
      ram_wr_en = 1'b1;
    end else if (cmd.tick_wr) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = tick_addr;
      ram_wr_data = {ram_rd_data[31:16], tm_dec};
    end else if (cmd.take_wr) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = take_slot;
      ram_wr_data = ram_rd_data;
    end else begin
      ram_wr_en = 1'b0;
    end
    priority if (cmd.deq_rd) begin
      ram_rd_en = 1'b1;
    end else if (cmd.tick_rd) begin
      ram_rd_en   = 1'b1;
      ram_rd_addr = tick_addr;
    end else if (cmd.take_rd) begin
      ram_rd_en   = 1'b1;
      ram_rd_addr = scan_slot;
    end else if (cmd.take_cap) begin
      ram_rd_en   = 1'b1;
      ram_rd_addr = last_slot;
    end else begin
      ram_rd_en = 1'b0;
    end
  end

  dwq_ram #(
    .WIDTH (dwq_pkg::DATA_W),
    .DEPTH (dwq_pkg::TOTAL)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < dwq_pkg::NUM_DEVICES; d++) begin
        head[d]  <= '0;
        tail[d]  <= '0;
        count[d] <= '0;
      end
      occ       <= '0;
      zf        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.enq) begin
        occ[tail_slot]  <= 1'b1;
        zf[tail_slot]   <= tim_q == '0;
        tail[dev_idx]   <= dwq_pkg::ring_add(tail[dev_idx], dwq_pkg::CNT_W'(1));
        count[dev_idx]  <= count[dev_idx] + dwq_pkg::CNT_W'(1);
      end
      if (cmd.deq_rd) begin
        occ[head_slot]  <= 1'b0;
        head[dev_idx]   <= dwq_pkg::ring_add(head[dev_idx], dwq_pkg::CNT_W'(1));
        count[dev_idx]  <= count[dev_idx] - dwq_pkg::CNT_W'(1);
      end
      if (cmd.tick_wr) begin
        zf[tick_addr] <= tm_dec == '0;
      end
      if (cmd.take_wr) begin
        zf[take_slot]   <= zf[last_slot];
        occ[last_slot]  <= 1'b0;
        tail[dev_idx]   <= tail_prev;
        count[dev_idx]  <= count[dev_idx] - dwq_pkg::CNT_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      kind       <= dwq_pkg::req_kind_t'(req_type);
      dev_q      <= device;
      pid_q      <= process_id;
      tim_q      <= io_time;
      scan_pos   <= '0;
      tick_addr  <= '0;
      res_status <= dwq_pkg::STS_OK;
      res_pid    <= '0;
      res_time   <= '0;
    end
    if (cmd.fail_full) begin
      res_status <= dwq_pkg::STS_FULL;
    end
    if (cmd.fail_none) begin
      res_status <= dwq_pkg::STS_NONE;
    end
    if (cmd.deq_cap || cmd.take_cap) begin
      res_pid  <= ram_rd_data[31:16];
      res_time <= ram_rd_data[15:0];
    end
    if (cmd.tick_wr) begin
      tick_addr <= tick_addr + dwq_pkg::ADDR_W'(1);
    end
    if (cmd.find_step) begin
      scan_pos <= scan_pos + dwq_pkg::CNT_W'(1);
    end
    if (cmd.take_rd) begin
      take_slot <= scan_slot;
    end
    if (cmd.load_out) begin
      status         <= res_status;
      out_process_id <= res_pid;
      out_time_left  <= res_time;
      finished_mask  <= mask;
      fill_count     <= dev_ok ? 5'(count[dev_idx]) : 5'd0;
    end
  end

endmodule

@@ design/device_wait_queues.sv @@
// ----------------------------------------------------------------------------
// device_wait_queues
// One ring queue of waiting processes per device, with enqueue, dequeue,
// countdown tick over all entries and removal of the first finished entry.
//
//   channel  dir  payload
//   req      in   req_type, device, process_id, io_time
//   rsp      out  status, out_process_id, out_time_left, finished_mask,
//                 fill_count
//
// Requests share the single read/write pair of the entry memory: a tick reads
// and writes back every slot in turn, and take-finished scans from the head
// up to the first finished entry, or over the whole queue when none is
// finished. One request is in work at a time. Reset is synchronous; the entry
// memory needs no clearing pass.
// A stalled response holds the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module device_wait_queues (
  input logic   clk,
  input logic   rst,
  dwq_req_if.sink   req,
  dwq_rsp_if.source rsp
);

  dwq_pkg::cmd_t cmd;
  dwq_pkg::sts_t sts;
  logic          ready;

  assign req.ready = ready;

  dwq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dwq_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_type       (req.req_type),
    .device         (req.device),
    .process_id     (req.process_id),
    .io_time        (req.io_time),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .status         (rsp.status),
    .out_process_id (rsp.out_process_id),
    .out_time_left  (rsp.out_time_left),
    .finished_mask  (rsp.finished_mask),
    .fill_count     (rsp.fill_count)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while another is in work");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("response loaded over an untaken response");

  a_fail_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != dwq_pkg::STS_OK) |->
      (rsp.out_process_id == 16'd0 && rsp.out_time_left == 16'd0))
    else $error("failed request returned an entry");

endmodule

@@ tb/sv/device_wait_queues_tb.sv @@
// ----------------------------------------------------------------------------
// device_wait_queues_tb
// Drives enqueue, dequeue, tick and take-finished requests into the device
// wait queues, predicts every response from a local copy of the queue state
// and compares the responses field by field, with random stalls on both sides.
// ----------------------------------------------------------------------------
module device_wait_queues_tb;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    dwq_pkg::req_kind_t kind;
    logic [1:0]         dev;
    logic [15:0]        pid;
    logic [15:0]        io_time;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pid;
    logic [15:0] time_left;
    logic [3:0]  mask;
    logic [4:0]  fill;
  } response_t;

  typedef struct {
    request_t  r;
    logic      known;
    response_t rsp;
  } vector_t;

  logic clk;
  logic rst;
  int   errors;
  int   idle_cycles = 0;
  bit   calm;

  dwq_req_if req ();
  dwq_rsp_if rsp ();

  device_wait_queues dut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  int          q_head [dwq_pkg::NUM_DEVICES];
  int          q_count [dwq_pkg::NUM_DEVICES];
  logic [15:0] q_pid [dwq_pkg::NUM_DEVICES][dwq_pkg::QUEUE_DEPTH];
  logic [15:0] q_time [dwq_pkg::NUM_DEVICES][dwq_pkg::QUEUE_DEPTH];
  response_t   pending_rsp [$];
  vector_t     directed [$];

  clocking mon_cb @(posedge clk);
    input rst;
    input in_valid  = req.valid;
    input in_ready  = req.ready;
    input out_valid = rsp.valid;
    input out_ready = rsp.ready;
    input status    = rsp.status;
    input out_pid   = rsp.out_process_id;
    input out_time  = rsp.out_time_left;
    input mask      = rsp.finished_mask;
    input fill      = rsp.fill_count;
  endclocking

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int first_done(int d);
    for (int i = 0; i < q_count[d]; i++) begin
      if (q_time[d][(q_head[d] + i) % dwq_pkg::QUEUE_DEPTH] == 16'd0) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic response_t apply_request(request_t r);
    response_t o;
    int d;
    int s;
    int last;
    int pos;
    d = int'(r.dev);
    o = '{default: '0};
    o.status = dwq_pkg::STS_OK;
    case (r.kind)
      dwq_pkg::REQ_ENQ: begin
        if (q_count[d] >= dwq_pkg::QUEUE_DEPTH) begin
          o.status = dwq_pkg::STS_FULL;
        end else begin
          s = (q_head[d] + q_count[d]) % dwq_pkg::QUEUE_DEPTH;
          q_pid[d][s] = r.pid;
          q_time[d][s] = r.io_time;
          q_count[d]++;
        end
      end
      dwq_pkg::REQ_DEQ: begin
        if (q_count[d] == 0) begin
          o.status = dwq_pkg::STS_NONE;
        end else begin
          o.pid = q_pid[d][q_head[d]];
          o.time_left = q_time[d][q_head[d]];
          q_head[d] = (q_head[d] + 1) % dwq_pkg::QUEUE_DEPTH;
          q_count[d]--;
        end
      end
      dwq_pkg::REQ_TICK: begin
        for (int k = 0; k < dwq_pkg::NUM_DEVICES; k++) begin
          for (int i = 0; i < q_count[k]; i++) begin
            s = (q_head[k] + i) % dwq_pkg::QUEUE_DEPTH;
            if (q_time[k][s] != 16'd0) begin
              q_time[k][s]--;
            end
          end
        end
      end
      default: begin
        pos = first_done(d);
        if (pos < 0) begin
          o.status = dwq_pkg::STS_NONE;
        end else begin
          s = (q_head[d] + pos) % dwq_pkg::QUEUE_DEPTH;
          last = (q_head[d] + q_count[d] - 1) % dwq_pkg::QUEUE_DEPTH;
          o.pid = q_pid[d][s];
          o.time_left = q_time[d][s];
          q_pid[d][s] = q_pid[d][last];
          q_time[d][s] = q_time[d][last];
          q_count[d]--;
        end
      end
    endcase
    for (int k = 0; k < dwq_pkg::NUM_DEVICES && k < 4; k++) begin
      if (first_done(k) >= 0) begin
        o.mask[k] = 1'b1;
      end
    end
    o.fill = 5'(q_count[d]);
    return o;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send(request_t r, logic known, response_t want);
    response_t p;
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= r.kind;
    req.device <= r.dev;
    req.process_id <= r.pid;
    req.io_time <= r.io_time;
    while (!req.ready) @(negedge clk);
    @(posedge clk);
    p = apply_request(r);
    if (known) begin
      if (p.status != want.status) report("directed status", p.status, want.status);
      if (p.pid != want.pid) report("directed out_process_id", p.pid, want.pid);
      if (p.time_left != want.time_left) begin
        report("directed out_time_left", p.time_left, want.time_left);
      end
      if (p.mask != want.mask) report("directed finished_mask", p.mask, want.mask);
      if (p.fill != want.fill) report("directed fill_count", p.fill, want.fill);
    end
    pending_rsp.push_back(p);
    @(negedge clk);
  endtask

  function automatic request_t rand_request(int phase);
    request_t r;
    int pick;
    r.dev = 2'($urandom_range(0, 3));
    r.pid = 16'($urandom);
    r.io_time = (phase == 0) ? 16'($urandom_range(0, 4)) : 16'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      r.io_time = 16'($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
    end
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      r.kind = dwq_pkg::REQ_ENQ;
    end else if (pick < 6) begin
      r.kind = dwq_pkg::REQ_DEQ;
    end else if (pick < 8) begin
      r.kind = dwq_pkg::REQ_TICK;
    end else begin
      r.kind = dwq_pkg::REQ_TAKE;
    end
    return r;
  endfunction

  function automatic vector_t row(dwq_pkg::req_kind_t k, int d, int p, int t, logic known,
                                  int st, int op, int ot, int m, int f);
    vector_t v;
    v.r = '{k, 2'(d), 16'(p), 16'(t)};
    v.known = known;
    v.rsp = '{2'(st), 16'(op), 16'(ot), 4'(m), 5'(f)};
    return v;
  endfunction

  always @(mon_cb) begin
    response_t w;
    if (!mon_cb.rst && mon_cb.out_valid && mon_cb.out_ready) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected response", 1, 0);
      end else begin
        w = pending_rsp.pop_front();
        if (mon_cb.status !== w.status) report("status", mon_cb.status, w.status);
        if (mon_cb.out_pid !== w.pid) report("out_process_id", mon_cb.out_pid, w.pid);
        if (mon_cb.out_time !== w.time_left) begin
          report("out_time_left", mon_cb.out_time, w.time_left);
        end
        if (mon_cb.mask !== w.mask) report("finished_mask", mon_cb.mask, w.mask);
        if (mon_cb.fill !== w.fill) report("fill_count", mon_cb.fill, w.fill);
      end
    end
  end

  always @(negedge clk) begin
    if (calm || $urandom_range(0, 3) != 0) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= 1'b0;
      repeat ($urandom_range(1, 10) - 1) @(negedge clk);
    end
  end

  always @(mon_cb) begin
    if ((mon_cb.in_valid && mon_cb.in_ready) || (mon_cb.out_valid && mon_cb.out_ready) ||
        mon_cb.rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 20000) begin
      $display("device_wait_queues test failed");
      $finish;
    end
  end

  initial begin
    request_t r;
    response_t none;
    errors = 0;
    calm = 1'b0;
    none = '{default: '0};
    rst = 1'b1;
    req.valid = 1'b0;
    req.req_type = dwq_pkg::REQ_ENQ;
    req.device = '0;
    req.process_id = '0;
    req.io_time = '0;
    for (int d = 0; d < dwq_pkg::NUM_DEVICES; d++) begin
      q_head[d] = 0;
      q_count[d] = 0;
    end
    directed.push_back(row(dwq_pkg::REQ_DEQ, 0, 0, 0, 1, dwq_pkg::STS_NONE, 0, 0, 0, 0));
    directed.push_back(row(dwq_pkg::REQ_TAKE, 3, 0, 0, 1, dwq_pkg::STS_NONE, 0, 0, 0, 0));
    directed.push_back(row(dwq_pkg::REQ_TICK, 0, 0, 0, 1, dwq_pkg::STS_OK, 0, 0, 0, 0));
    directed.push_back(row(dwq_pkg::REQ_ENQ, 1, 16'hFFFF, 16'hFFFF, 1, dwq_pkg::STS_OK,
                           0, 0, 0, 1));
    directed.push_back(row(dwq_pkg::REQ_ENQ, 1, 0, 0, 1, dwq_pkg::STS_OK, 0, 0, 2, 2));
    directed.push_back(row(dwq_pkg::REQ_ENQ, 1, 16'h1234, 1, 1, dwq_pkg::STS_OK,
                           0, 0, 2, 3));
    directed.push_back(row(dwq_pkg::REQ_TAKE, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(dwq_pkg::REQ_TICK, 2, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(dwq_pkg::REQ_TAKE, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(dwq_pkg::REQ_TAKE, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(dwq_pkg::REQ_DEQ, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(dwq_pkg::REQ_DEQ, 1, 0, 0, 1, dwq_pkg::STS_NONE, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++) begin
      directed.push_back(row(dwq_pkg::REQ_ENQ, 3, 16'hA000 + i, 16'h5555 ^ i, 0,
                             0, 0, 0, 0, 0));
    end
    directed.push_back(row(dwq_pkg::REQ_DEQ, 3, 0, 0, 1, dwq_pkg::STS_OK, 16'hA000,
                           16'h5555, 0, 15));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed[i]) send(directed[i].r, directed[i].known, directed[i].rsp);
    for (int n = 0; n < 1700; n++) begin
      if (n == 600) begin
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge clk);
      end
      if (n == 1450) calm = 1'b1;
      r = rand_request(n < 900 ? 0 : 1);
      send(r, 1'b0, none);
    end
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (2 * dwq_pkg::NUM_DEVICES * dwq_pkg::QUEUE_DEPTH + 20) @(posedge clk);
    if (errors == 0) begin
      $display("device_wait_queues test passed");
    end else begin
      $display("device_wait_queues test failed");
    end
    $finish;
  end
endmodule
